// ----- rtl/img_pad_pkg.sv -----
// ----------------------------------------------------------------------------
// img_pad_pkg
// Shared widths, register indexes and format codes for the border padder.
// ----------------------------------------------------------------------------
package img_pad_pkg;

  localparam int unsigned PixW    = 24;
  localparam int unsigned DimW    = 14;
  localparam int unsigned BordW   = 12;
  localparam int unsigned SumW    = DimW + 1;
  localparam int unsigned CtrlW   = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 24;

  localparam logic [DimW-1:0]  MaxImageDim = DimW'(8192);
  localparam logic [BordW-1:0] MaxBorder   = BordW'(4095);

  typedef logic [PixW-1:0]    pixel_t;
  typedef logic [DimW-1:0]    dim_t;
  typedef logic [BordW-1:0]   bord_t;
  typedef logic [SumW-1:0]    sum_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  typedef logic [CfgDatW-1:0] cfg_dat_t;

  // register indexes
  localparam cfg_idx_t RegBorderLeft   = 3'd0;
  localparam cfg_idx_t RegBorderRight  = 3'd1;
  localparam cfg_idx_t RegBorderTop    = 3'd2;
  localparam cfg_idx_t RegBorderBottom = 3'd3;
  localparam cfg_idx_t RegImageWidth   = 3'd4;
  localparam cfg_idx_t RegImageHeight  = 3'd5;
  localparam cfg_idx_t RegBorderColor  = 3'd6;
  localparam cfg_idx_t RegControl      = 3'd7;

  // pixel format codes, control[1:0]
  localparam logic [1:0] FmtRgb24  = 2'd0;
  localparam logic [1:0] FmtRgb565 = 2'd1;
  localparam logic [1:0] FmtIndex8 = 2'd2;

  // control bit positions
  localparam int unsigned CtrlCentred  = 2;
  localparam int unsigned CtrlUseFirst = 3;

endpackage

// ----- rtl/img_pad_if.sv -----
// ----------------------------------------------------------------------------
// img_pad_if
// Valid/ready channel interfaces: source pixels, padded results, config.
// ----------------------------------------------------------------------------
interface img_pad_src_if;
  import img_pad_pkg::*;

  logic   valid;
  logic   ready;
  pixel_t src_pixel;

  modport source (output valid, output src_pixel, input ready);
  modport sink   (input valid, input src_pixel, output ready);
endinterface

interface img_pad_res_if;
  import img_pad_pkg::*;

  logic   valid;
  logic   ready;
  pixel_t out_pixel;
  logic   src_consumed;
  logic   row_end;
  logic   frame_end;

  modport source (output valid, output out_pixel, output src_consumed,
                  output row_end, output frame_end, input ready);
  modport sink   (input valid, input out_pixel, input src_consumed,
                  input row_end, input frame_end, output ready);
endinterface

interface img_pad_cfg_if;
  import img_pad_pkg::*;

  logic     valid;
  logic     ready;
  cfg_idx_t addr;
  cfg_dat_t data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

// ----- rtl/image_border_padder_unit.sv -----
// ----------------------------------------------------------------------------
// image_border_padder_unit
// Constant-border image padder: one output pixel for every source transfer.
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                                   notes
//  -------  ---  ----------------------------------------  --------------------
//  src_i    in   src_pixel                                 one per output pixel
//  res_o    out  out_pixel, src_consumed, row_end,         registered
//                frame_end
//  cfg_i    in   addr (register index), data               always ready
//
//  Each source transfer yields exactly one result, registered on the same
//  edge; it appears on res_o in the next cycle. Throughput is one pixel
//  per clock unless res_o stalls, set by the single result register.
//  src_i stays ready while the result register is empty or being drained,
//  so a stall on res_o stalls src_i in the same cycle. Reset clears the
//  counters, the latched fill and the registers to their defaults (image
//  1x1, no border, RGB24).
module image_border_padder_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  img_pad_src_if.sink            src_i,
  img_pad_res_if.source          res_o,
  img_pad_cfg_if.sink            cfg_i
);
  import img_pad_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  bord_t              bord_left_q, bord_right_q, bord_top_q, bord_bottom_q;
  dim_t               img_width_q, img_height_q;
  pixel_t             bord_color_q;
  logic [CtrlW-1:0]   control_q;
  logic               cfg_we;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid & cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bord_left_q   <= '0;
      bord_right_q  <= '0;
      bord_top_q    <= '0;
      bord_bottom_q <= '0;
      img_width_q   <= DimW'(1);
      img_height_q  <= DimW'(1);
      bord_color_q  <= '0;
      control_q     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_i.addr)
        RegBorderLeft:   bord_left_q   <= cfg_i.data[BordW-1:0];
        RegBorderRight:  bord_right_q  <= cfg_i.data[BordW-1:0];
        RegBorderTop:    bord_top_q    <= cfg_i.data[BordW-1:0];
        RegBorderBottom: bord_bottom_q <= cfg_i.data[BordW-1:0];
        RegImageWidth:   img_width_q   <= cfg_i.data[DimW-1:0];
        RegImageHeight:  img_height_q  <= cfg_i.data[DimW-1:0];
        RegBorderColor:  bord_color_q  <= cfg_i.data[PixW-1:0];
        RegControl:      control_q     <= cfg_i.data[CtrlW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Effective geometry (derived combinationally; the user must change config only while idle, not enforced here)
  // --------------------------------------------------------------------------
  logic [1:0] fmt;
  logic       centred, use_first;
  dim_t       w_eff, h_eff;
  bord_t      bl_clamp, br_clamp, bt_clamp, bb_clamp;
  bord_t      bl_eff, br_eff, bt_eff, bb_eff;
  logic [BordW:0] bl_up, bt_up;
  sum_t       left_end, top_end, out_w, out_h, last_col, last_row;

  assign fmt       = control_q[1:0];
  assign centred   = control_q[CtrlCentred];
  assign use_first = control_q[CtrlUseFirst];

  function automatic dim_t clamp_dim(dim_t v);
    dim_t r;
    if (v == '0)              r = DimW'(1);
    else if (v > MaxImageDim) r = MaxImageDim;
    else                      r = v;
    return r;
  endfunction

  function automatic bord_t clamp_bord(bord_t v);
    return (v > MaxBorder) ? MaxBorder : v;
  endfunction

  assign w_eff    = clamp_dim(img_width_q);
  assign h_eff    = clamp_dim(img_height_q);
  assign bl_clamp = clamp_bord(bord_left_q);
  assign br_clamp = clamp_bord(bord_right_q);
  assign bt_clamp = clamp_bord(bord_top_q);
  assign bb_clamp = clamp_bord(bord_bottom_q);

  // centred: larger half goes left/top
  assign bl_up = {1'b0, bl_clamp} + (BordW+1)'(1);
  assign bt_up = {1'b0, bt_clamp} + (BordW+1)'(1);

  always_comb begin
    if (centred) begin
      bl_eff = bl_up[BordW:1];
      br_eff = bl_clamp >> 1;
      bt_eff = bt_up[BordW:1];
      bb_eff = bt_clamp >> 1;
    end else begin
      bl_eff = bl_clamp;
      br_eff = br_clamp;
      bt_eff = bt_clamp;
      bb_eff = bb_clamp;
    end
  end

  assign left_end = SumW'(bl_eff) + SumW'(w_eff);
  assign top_end  = SumW'(bt_eff) + SumW'(h_eff);
  assign out_w    = left_end + SumW'(br_eff);
  assign out_h    = top_end + SumW'(bb_eff);
  assign last_col = out_w - SumW'(1);
  assign last_row = out_h - SumW'(1);

  // --------------------------------------------------------------------------
  // Raster counters and pixel selection
  // --------------------------------------------------------------------------
  dim_t   col_q, col_d, row_q, row_d;
  pixel_t fill_q, fill_d;
  logic   in_acc, frame_start, in_win, rend, fend;
  pixel_t fill_pix, raw_pix, masked_pix;

  // result register
  logic   res_vld_q;
  pixel_t res_pix_q;
  logic   res_cons_q, res_rend_q, res_fend_q;

  assign src_i.ready = ~res_vld_q | res_o.ready;
  assign in_acc      = src_i.valid & src_i.ready;

  assign frame_start = (col_q == '0) && (row_q == '0);
  assign fill_d      = (in_acc && frame_start) ? src_i.src_pixel : fill_q;

  always_comb begin
    if (use_first) begin
      fill_pix = fill_d;
    end else if (fmt == FmtRgb565) begin
      fill_pix = {8'h00, bord_color_q[23:19], bord_color_q[15:10], bord_color_q[7:3]};
    end else begin
      fill_pix = bord_color_q;
    end
  end

  assign in_win  = ({1'b0, col_q} >= SumW'(bl_eff)) && ({1'b0, col_q} < left_end) &&
                   ({1'b0, row_q} >= SumW'(bt_eff)) && ({1'b0, row_q} < top_end);
  assign raw_pix = in_win ? src_i.src_pixel : fill_pix;

  always_comb begin
    unique case (fmt)
      FmtRgb565: masked_pix = {8'h00, raw_pix[15:0]};
      FmtIndex8: masked_pix = {16'h0000, raw_pix[7:0]};
      default:   masked_pix = raw_pix;
    endcase
  end

  // a counter past a shrunken frame ends the row / frame at once
  assign rend = ({1'b0, col_q} >= last_col);
  assign fend = rend && ({1'b0, row_q} >= last_row);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (rend) begin
        col_d = '0;
        row_d = fend ? '0 : row_q + DimW'(1);
      end else begin
        col_d = col_q + DimW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      fill_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (src_i.ready) begin
      res_vld_q <= src_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_pix_q  <= masked_pix;
      res_cons_q <= in_win;
      res_rend_q <= rend;
      res_fend_q <= fend;
    end
  end

  assign res_o.valid        = res_vld_q;
  assign res_o.out_pixel    = res_pix_q;
  assign res_o.src_consumed = res_cons_q;
  assign res_o.row_end      = res_rend_q;
  assign res_o.frame_end    = res_fend_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_acc_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> res_o.valid)
    else $error("accepted pixel produced no result");

  a_fill_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && frame_start) |=> (fill_q == $past(src_i.src_pixel)))
    else $error("first pixel of frame not latched");

  a_col_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !rend) |=> (col_q == $past(col_q) + DimW'(1)))
    else $error("column counter did not advance");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.ready) |-> !src_i.ready)
    else $error("source accepted while result stalled");

endmodule

// ----- tb/img_pad_checker.sv -----
// ----------------------------------------------------------------------------
// img_pad_checker
// Watches the source, result and register channels of the border padder.
// Keeps its own copy of the registers and counters, predicts each padded
// pixel and compares it with what comes out of the result channel.
// ----------------------------------------------------------------------------
module img_pad_checker
  import img_pad_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  img_pad_src_if src_i,
  img_pad_res_if res_i,
  img_pad_cfg_if cfg_i,
  output int     fail_count_o,
  output int     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxReports = 10;

  typedef struct packed {
    pixel_t out_pixel;
    logic   src_consumed;
    logic   row_end;
    logic   frame_end;
  } padded_px_t;

  // shadow registers
  bord_t            left_bord, right_bord, top_bord, bottom_bord;
  dim_t             width_reg, height_reg;
  pixel_t           colour_reg;
  logic [CtrlW-1:0] ctrl_reg;

  // output position and first-pixel fill
  dim_t   col_cnt, row_cnt;
  pixel_t fill_lat;

  padded_px_t expected_px [$];

  function automatic sum_t clamp_dim(input dim_t v);
    if (v == '0) return sum_t'(1);
    if (v > MaxImageDim) return sum_t'(MaxImageDim);
    return sum_t'(v);
  endfunction

  // Next padded pixel for one source offer; advances the position.
  function automatic padded_px_t pad_pixel(input pixel_t src);
    logic [1:0] fmt;
    sum_t       w, h, bl, br, bt, bb, nw, nh;
    pixel_t     mask, fill;
    padded_px_t r;
    fmt = ctrl_reg[1:0];
    w   = clamp_dim(width_reg);
    h   = clamp_dim(height_reg);
    // 12-bit registers never exceed MaxBorder
    bl  = sum_t'(left_bord);
    br  = sum_t'(right_bord);
    bt  = sum_t'(top_bord);
    bb  = sum_t'(bottom_bord);
    if (ctrl_reg[CtrlCentred]) begin
      br = bl >> 1;
      bl = (bl + 1'b1) >> 1;
      bb = bt >> 1;
      bt = (bt + 1'b1) >> 1;
    end
    nw = bl + w + br;
    nh = bt + h + bb;

    if (col_cnt == '0 && row_cnt == '0) fill_lat = src;

    if (ctrl_reg[CtrlUseFirst]) begin
      fill = fill_lat;
    end else if (fmt == FmtRgb565) begin
      fill = {8'h00, colour_reg[23:19], colour_reg[15:10], colour_reg[7:3]};
    end else begin
      fill = colour_reg;
    end

    case (fmt)
      FmtRgb565: mask = 24'h00ffff;
      FmtIndex8: mask = 24'h0000ff;
      default:   mask = '1;
    endcase

    r.src_consumed = (col_cnt >= bl) && (col_cnt < bl + w) &&
                     (row_cnt >= bt) && (row_cnt < bt + h);
    r.out_pixel    = (r.src_consumed ? src : fill) & mask;
    r.row_end      = (col_cnt >= nw - 1'b1);
    r.frame_end    = r.row_end && (row_cnt >= nh - 1'b1);

    if (r.row_end) begin
      col_cnt = '0;
      row_cnt = r.frame_end ? '0 : row_cnt + 1'b1;
    end else begin
      col_cnt = col_cnt + 1'b1;
    end
    return r;
  endfunction

  task automatic flag_fail(input string what, input padded_px_t want,
                           input padded_px_t got);
    fail_count_o++;
    if (fail_count_o <= MaxReports) begin
      $display("%0t: %s: expected pix %06h used %b row_end %b frame_end %b",
               $realtime, what, want.out_pixel, want.src_consumed, want.row_end,
               want.frame_end);
      $display("%0t: %s: actual   pix %06h used %b row_end %b frame_end %b",
               $realtime, what, got.out_pixel, got.src_consumed, got.row_end,
               got.frame_end);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    padded_px_t want, got;
    if (!rst_ni) begin
      left_bord   = '0;
      right_bord  = '0;
      top_bord    = '0;
      bottom_bord = '0;
      width_reg   = dim_t'(1);
      height_reg  = dim_t'(1);
      colour_reg  = '0;
      ctrl_reg    = '0;
      col_cnt     = '0;
      row_cnt     = '0;
      fill_lat    = '0;
      expected_px.delete();
      pending_o   = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.addr)
          RegBorderLeft:   left_bord   = cfg_i.data[BordW-1:0];
          RegBorderRight:  right_bord  = cfg_i.data[BordW-1:0];
          RegBorderTop:    top_bord    = cfg_i.data[BordW-1:0];
          RegBorderBottom: bottom_bord = cfg_i.data[BordW-1:0];
          RegImageWidth:   width_reg   = cfg_i.data[DimW-1:0];
          RegImageHeight:  height_reg  = cfg_i.data[DimW-1:0];
          RegBorderColor:  colour_reg  = cfg_i.data[PixW-1:0];
          RegControl:      ctrl_reg    = cfg_i.data[CtrlW-1:0];
          default: ;
        endcase
      end

      if (res_i.valid && res_i.ready) begin
        got = {res_i.out_pixel, res_i.src_consumed, res_i.row_end, res_i.frame_end};
        if (expected_px.size() == 0) begin
          flag_fail("result with nothing pending", '0, got);
        end else begin
          want = expected_px.pop_front();
          if (got !== want) flag_fail("pixel mismatch", want, got);
        end
      end

      if (src_i.valid && src_i.ready) expected_px.push_back(pad_pixel(src_i.src_pixel));

      pending_o = expected_px.size();
    end
  end

endmodule

// ----- tb/image_border_padder_unit_tb.sv -----
// ----------------------------------------------------------------------------
// image_border_padder_unit_tb
// Drives source pixels and register writes into the border padder, stalls
// the result channel at random and reports the checker's verdict.
// ----------------------------------------------------------------------------
module image_border_padder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import img_pad_pkg::*;

  localparam int ClkPeriod = 8;
  localparam int RandItems = 1500;   // source transfers counted from the largest-settings bursts on

  logic clk_i = 1'b0;
  logic rst_ni;
  int   fail_count;
  int   pending;     // predicted pixels not yet seen on the result channel

  img_pad_src_if src_if ();
  img_pad_res_if res_if ();
  img_pad_cfg_if cfg_if ();

  // register image for the next batch of writes; reg_wr marks which go out
  cfg_dat_t reg_val [8];
  bit       reg_wr  [8];
  bit       no_gaps;   // set for a back-to-back stretch on the source side
  int       sent;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  image_border_padder_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .src_i  (src_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  img_pad_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .src_i        (src_if),
    .res_i        (res_if),
    .cfg_i        (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Source pixels lean on the all-zero and all-one extremes now and then.
  function automatic pixel_t rand_px();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return pixel_t'($urandom);
  endfunction

  // Border widths: mostly tiny so frames complete, rarely up to the maximum.
  function automatic cfg_dat_t rand_border();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return cfg_dat_t'($urandom_range(0, 3));
    if (r < 95) return cfg_dat_t'($urandom_range(4, 9));
    return cfg_dat_t'($urandom_range(10, 4095));
  endfunction

  // Image sizes: zero and oversize both exercise the clamp.
  function automatic cfg_dat_t rand_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return cfg_dat_t'($urandom_range(1, 6));
    if (r < 92) return '0;
    if (r < 96) return cfg_dat_t'($urandom_range(7, 16));
    return cfg_dat_t'($urandom_range(8189, 16383));
  endfunction

  // Sometimes set the data bits above the register's width; they must be ignored.
  function automatic cfg_dat_t junk_above(input cfg_dat_t v, input int unsigned w);
    if ($urandom_range(0, 3) == 0) return v | (cfg_dat_t'($urandom) << w);
    return v;
  endfunction

  // Result side: ready high for a while, then a stall of random length.
  initial begin : res_stall
    int n;
    res_if.ready = 1'b0;
    forever begin
      n = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
      repeat (n) begin
        @(negedge clk_i);
        res_if.ready <= 1'b1;
      end
      n = pick_gap();
      repeat (n) begin
        @(negedge clk_i);
        res_if.ready <= 1'b0;
      end
    end
  end

  // Writes the marked registers back to back; valid drops only after the last.
  task automatic apply_config();
    foreach (reg_wr[i]) begin
      if (reg_wr[i]) begin
        cfg_if.valid <= 1'b1;
        cfg_if.addr  <= cfg_idx_t'(i);
        cfg_if.data  <= reg_val[i];
        do @(posedge clk_i); while (!cfg_if.ready);
        @(negedge clk_i);
      end
    end
    cfg_if.valid <= 1'b0;
  endtask

  // One source transfer. Entered and left at a falling edge; valid stays
  // high across back-to-back transfers.
  task automatic send_px(input pixel_t px);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      src_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    src_if.valid     <= 1'b1;
    src_if.src_pixel <= px;
    do @(posedge clk_i); while (!src_if.ready);
    @(negedge clk_i);
    sent++;
  endtask

  // Close a burst and let every predicted pixel drain: the block is then idle
  // and may take register writes. One result per transfer, so nothing lingers.
  task automatic drain();
    src_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic run_burst(input int n);
    no_gaps = ($urandom_range(0, 4) == 0);
    repeat (n) send_px(rand_px());
    drain();
  endtask

  // Fresh random settings; each register goes out with even odds.
  task automatic rand_config();
    foreach (reg_wr[i]) reg_wr[i] = ($urandom_range(0, 1) == 1);
    reg_val[RegBorderLeft]   = junk_above(rand_border(), BordW);
    reg_val[RegBorderRight]  = junk_above(rand_border(), BordW);
    reg_val[RegBorderTop]    = junk_above(rand_border(), BordW);
    reg_val[RegBorderBottom] = junk_above(rand_border(), BordW);
    reg_val[RegImageWidth]   = junk_above(rand_dim(), DimW);
    reg_val[RegImageHeight]  = junk_above(rand_dim(), DimW);
    reg_val[RegBorderColor]  = cfg_dat_t'($urandom);
    reg_val[RegControl]      = junk_above(cfg_dat_t'($urandom_range(0, 15)), CtrlW);
    apply_config();
  endtask

  initial begin : stimulus
    logic [CtrlW-1:0] ctrl;
    int               target;

    src_if.valid     = 1'b0;
    src_if.src_pixel = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.addr      = '0;
    cfg_if.data      = '0;
    rst_ni           = 1'b0;
    sent             = 0;
    no_gaps          = 1'b0;
    foreach (reg_wr[i]) begin
      reg_wr[i]  = 1'b0;
      reg_val[i] = '0;
    end

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: 1x1 image, no border, RGB24 - every pixel passes
    // straight through and ends both its row and its frame.
    send_px('1);
    send_px('0);
    send_px(24'h5a5a5a);
    drain();

    // RGB565 with a one-pixel frame round a 1x1 image: 3x3 output, the
    // centre pixel is the only source pixel consumed, the rest is packed colour.
    foreach (reg_wr[i]) reg_wr[i] = 1'b1;
    ctrl                     = '0;
    ctrl[1:0]                = FmtRgb565;
    reg_val[RegBorderLeft]   = cfg_dat_t'(1);
    reg_val[RegBorderRight]  = cfg_dat_t'(1);
    reg_val[RegBorderTop]    = cfg_dat_t'(1);
    reg_val[RegBorderBottom] = cfg_dat_t'(1);
    reg_val[RegImageWidth]   = cfg_dat_t'(1);
    reg_val[RegImageHeight]  = cfg_dat_t'(1);
    reg_val[RegBorderColor]  = cfg_dat_t'(24'ha5c37e);
    reg_val[RegControl]      = cfg_dat_t'(ctrl);
    apply_config();
    for (int i = 0; i < 9; i++) send_px((i == 4) ? '1 : rand_px());
    drain();

    // Index8, centred, border from the first pixel. Odd horizontal total
    // splits 2 left / 1 right, vertical 1 top / 0 bottom; the right and
    // bottom settings are at maximum but must be ignored.
    foreach (reg_wr[i]) reg_wr[i] = 1'b0;
    ctrl                     = '0;
    ctrl[1:0]                = FmtIndex8;
    ctrl[CtrlCentred]        = 1'b1;
    ctrl[CtrlUseFirst]       = 1'b1;
    reg_val[RegBorderLeft]   = cfg_dat_t'(3);
    reg_val[RegBorderRight]  = cfg_dat_t'(MaxBorder);
    reg_val[RegBorderTop]    = cfg_dat_t'(1);
    reg_val[RegBorderBottom] = cfg_dat_t'(MaxBorder);
    reg_val[RegControl]      = cfg_dat_t'(ctrl);
    reg_wr[RegBorderLeft]    = 1'b1;
    reg_wr[RegBorderRight]   = 1'b1;
    reg_wr[RegBorderTop]     = 1'b1;
    reg_wr[RegBorderBottom]  = 1'b1;
    reg_wr[RegControl]       = 1'b1;
    apply_config();
    send_px(24'h3c5af1);
    repeat (7) send_px(rand_px());
    drain();

    target = sent + RandItems;

    // Largest settings, non-centred RGB24: only the start of one very wide
    // row is streamed, the column counter climbs well past any small frame.
    foreach (reg_wr[i]) reg_wr[i] = 1'b1;
    reg_val[RegBorderLeft]   = cfg_dat_t'(MaxBorder);
    reg_val[RegBorderRight]  = cfg_dat_t'(MaxBorder);
    reg_val[RegBorderTop]    = cfg_dat_t'(MaxBorder);
    reg_val[RegBorderBottom] = cfg_dat_t'(MaxBorder);
    reg_val[RegImageWidth]   = cfg_dat_t'(MaxImageDim);
    reg_val[RegImageHeight]  = cfg_dat_t'(MaxImageDim);
    reg_val[RegBorderColor]  = '1;
    reg_val[RegControl]      = cfg_dat_t'(FmtRgb24);
    apply_config();
    run_burst(30);

    // Centred with odd maximum totals, unused format code, first-pixel fill,
    // zero width and oversize height (both clamped), junk in the upper bits.
    ctrl                     = '1;
    reg_val[RegImageWidth]   = cfg_dat_t'(24'hffc000);
    reg_val[RegImageHeight]  = cfg_dat_t'(14'h3fff);
    reg_val[RegBorderColor]  = cfg_dat_t'($urandom);
    reg_val[RegControl]      = cfg_dat_t'({20'hfffff, ctrl});
    apply_config();
    run_burst(30);

    // Random settings between bursts. Bursts need not end on a frame
    // boundary, so counters often lie beyond a freshly shrunk frame.
    while (sent < target) begin
      rand_config();
      if ($urandom_range(0, 29) == 0) run_burst($urandom_range(1, 40));
      else run_burst($urandom_range(1, 120));
    end

    // Every pixel is back; allow a few cycles for anything stray.
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #4ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
